// ===== design/prtd_pkg.sv =====
// prtd_pkg: shared types, sizes and codes of the pixel run token decoder
// no dependencies; imported by every design module and the checker
package prtd_pkg;

  // line store and field sizes
  localparam int MAX_WIDTH   = 4096;
  localparam int LS_AW       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 13;
  localparam int COL_W       = 12;
  localparam int ROW_W       = 16;
  localparam int RUN_W       = 8;
  localparam int COLOR_W     = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd1920;

  // token kinds as reported on the result channel
  localparam logic [2:0] KIND_COPY_TOP  = 3'd0;
  localparam logic [2:0] KIND_COPY_LEFT = 3'd1;
  localparam logic [2:0] KIND_SHORT     = 3'd2;
  localparam logic [2:0] KIND_REPEAT    = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  // marker byte of a repeat token
  localparam logic [7:0] REPEAT_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [RUN_W-1:0] run_length;
    logic [COL_W-1:0] start_column;
    logic [ROW_W-1:0] start_row;
    logic [2:0]       token_kind;
  } out_item_t;

  // command handed from the parser to the run engine
  typedef struct packed {
    logic               pos_reset;
    logic               has_token;
    logic [2:0]         kind;
    logic [COLOR_W-1:0] color;
    logic [RUN_W-1:0]   run;
  } token_t;

  // width actually used: zero acts as one, clamp at the line store size
  function automatic logic [WIDTH_W-1:0] active_width(input logic [WIDTH_W-1:0] fw);
    logic [WIDTH_W-1:0] w;
    w = fw;
    if (fw == '0) begin
      w = WIDTH_W'(1);
    end else if (fw > WIDTH_W'(MAX_WIDTH)) begin
      w = WIDTH_W'(MAX_WIDTH);
    end
    return w;
  endfunction

endpackage

// ===== design/pixel_run_token_decoder.sv =====
// pixel_run_token_decoder: top level of the screen stream run token decoder
// depends on prtd_pkg, prtd_front, prtd_fifo and prtd_back
//
// Takes one stream byte per accepted item and emits one result item per
// completed 2- or 3-byte token: colour, run length, raster start position and
// token kind. The parser accepts a byte per cycle while the 4-entry token queue
// has room and no clear runs; the run engine pops a token, folds the column
// by restoring division when it lies past the width, reads the line store,
// offers the result item, waiting while the previous one is not taken, and
// writes every pixel of the run into the line store. A frame start byte that
// completes no token is still popped. After reset the line store is cleared
// while in_ready stays low. The user must write frame_width through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
module pixel_run_token_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  prtd_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output prtd_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [prtd_pkg::WIDTH_W-1:0] cfg_wdata
);
  import prtd_pkg::*;

  logic [WIDTH_W-1:0] frame_width_r;
  logic               clearing;
  logic               q_push, q_full, q_pop, q_empty;
  token_t             q_data, q_head;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= RESET_WIDTH;
    end else if (cfg_we) begin
      frame_width_r <= cfg_wdata;
    end
  end

  // byte parser
  prtd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // token queue
  prtd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // run engine
  prtd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_width (frame_width_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

// ===== design/prtd_front.sv =====
// prtd_front: byte parser, groups stream bytes into tokens and decodes colours
// depends on prtd_pkg; feeds the token queue
module prtd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prtd_pkg::in_item_t in_item,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output prtd_pkg::token_t  q_data
);
  import prtd_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [7:0] held2_r, held2_nxt;
  logic       accept;
  logic [1:0] phase_e;
  logic [7:0] b;
  logic [15:0] full_c;
  token_t     tok;

  // accept bytes once the line store is cleared and the queue has room
  assign in_ready = !clearing && !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_item.stream_byte;
  assign full_c   = {held1_r, b};

  // token decode
  always_comb begin
    phase_nxt     = phase_r;
    held1_nxt     = held1_r;
    held2_nxt     = held2_r;
    tok           = '0;
    tok.pos_reset = in_item.frame_start;
    phase_e       = in_item.frame_start ? PH_FIRST : phase_r;
    case (phase_e)
      PH_SECOND: begin
        held2_nxt = b;
        phase_nxt = PH_FIRST;
        if (b == 8'd0) begin
          tok.has_token = 1'b1;
          tok.kind      = (held1_r == 8'd0) ? KIND_COPY_TOP : KIND_COPY_LEFT;
          tok.run       = RUN_W'(1);
        end else if (held1_r[6]) begin
          tok.has_token = 1'b1;
          tok.kind      = KIND_SHORT;
          tok.run       = {1'b0, b[6:0]};
          if (b[7]) begin
            tok.color = {held1_r[5:4], 6'b0, held1_r[3:2], 6'b0, held1_r[1:0], 6'b0};
          end else begin
            tok.color = {2'b0, held1_r[5:4], 4'b0, 3'b0, held1_r[3:2], 3'b0,
                         3'b0, held1_r[1:0], 3'b0};
          end
        end else if (held1_r == REPEAT_MARK) begin
          tok.has_token = 1'b1;
          tok.kind      = KIND_REPEAT;
          tok.run       = b;
        end else begin
          phase_nxt = PH_THIRD;
        end
      end
      PH_THIRD: begin
        // 4:5:5 colour from first and third byte, run from second
        tok.has_token = 1'b1;
        tok.kind      = KIND_FULL;
        tok.run       = held2_r;
        tok.color     = {full_c[13:10], 4'b0, full_c[9:5], 3'b0, full_c[4:0], 3'b0};
        phase_nxt     = PH_FIRST;
      end
      default: begin
        held1_nxt = b;
        phase_nxt = PH_SECOND;
      end
    endcase
  end

  // queue push for tokens and position resets
  assign q_push = accept && (in_item.frame_start || tok.has_token);
  assign q_data = tok;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held1_r <= '0;
      held2_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
    end
  end

endmodule

// ===== design/prtd_fifo.sv =====
// prtd_fifo: short token queue between the parser and the run engine
// depends on prtd_pkg for the token type and depth
module prtd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prtd_pkg::token_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output prtd_pkg::token_t head
);
  import prtd_pkg::*;

  token_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== design/prtd_back.sv =====
// prtd_back: run engine with line store, position tracking and result register
// depends on prtd_pkg; pops commands from prtd_fifo
module prtd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [prtd_pkg::WIDTH_W-1:0] frame_width,
  input  logic                         q_empty,
  input  prtd_pkg::token_t             q_head,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output prtd_pkg::out_item_t          out_item
);
  import prtd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FOLD, S_READ, S_RESOLVE, S_WRITE
  } state_t;

  state_t             state_r, state_nxt;
  logic [LS_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [3:0]         step_r, step_nxt;
  token_t             tok_r, tok_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [RUN_W-1:0]   cnt_r, cnt_nxt;
  logic [COLOR_W-1:0] last_color_r, last_color_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [COLOR_W-1:0] mem [MAX_WIDTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic               mem_we;
  logic [LS_AW-1:0]   mem_wa, mem_ra;
  logic [COLOR_W-1:0] mem_wd;

  logic [WIDTH_W-1:0] w;
  logic [WIDTH_W-1:0] w_m1;
  logic [COL_W-1:0]   col_e, left_idx;
  logic [ROW_W-1:0]   row_e;
  logic [23:0]        fold_sub;
  logic [COLOR_W-1:0] color_sel;

  assign w         = active_width(frame_width);
  assign w_m1      = w - WIDTH_W'(1);
  assign left_idx  = (col_r == '0) ? w_m1[COL_W-1:0] : col_r - COL_W'(1);
  assign fold_sub  = {11'b0, w} << step_r;
  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // colour of the current token: line store for copies, held colour for repeat, token colour otherwise
  always_comb begin
    if (tok_r.kind == KIND_COPY_TOP || tok_r.kind == KIND_COPY_LEFT) begin
      color_sel = rd_data_r;
    end else if (tok_r.kind == KIND_REPEAT) begin
      color_sel = last_color_r;
    end else begin
      color_sel = tok_r.color;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    step_nxt       = step_r;
    tok_nxt        = tok_r;
    color_nxt      = color_r;
    cnt_nxt        = cnt_r;
    last_color_nxt = last_color_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = col_r[LS_AW-1:0];
    mem_wd         = color_r;
    mem_ra         = col_r[LS_AW-1:0];
    col_e          = col_r;
    row_e          = row_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = '0;
        clr_addr_nxt = clr_addr_r + LS_AW'(1);
        if (clr_addr_r == LS_AW'(MAX_WIDTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          tok_nxt = q_head;
          col_e   = q_head.pos_reset ? '0 : col_r;
          row_e   = q_head.pos_reset ? '0 : row_r;
          col_nxt = col_e;
          row_nxt = row_e;
          if (q_head.has_token) begin
            if ({1'b0, col_e} >= w) begin
              step_nxt  = 4'(COL_W - 1);
              state_nxt = S_FOLD;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_FOLD: begin
        // restoring division of the column by the width, one quotient bit a cycle
        if ({12'b0, col_r} >= fold_sub) begin
          col_nxt = col_r - fold_sub[COL_W-1:0];
          row_nxt = row_r + (ROW_W'(1) << step_r);
        end
        if (step_r == '0) begin
          state_nxt = S_READ;
        end else begin
          step_nxt = step_r - 4'd1;
        end
      end
      S_READ: begin
        if (tok_r.kind == KIND_COPY_LEFT) begin
          mem_ra = left_idx[LS_AW-1:0];
        end
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        // keep the read address so a stalled copy sees the same pixel
        if (tok_r.kind == KIND_COPY_LEFT) begin
          mem_ra = left_idx[LS_AW-1:0];
        end
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.red          = color_sel[23:16];
          out_item_nxt.green        = color_sel[15:8];
          out_item_nxt.blue         = color_sel[7:0];
          out_item_nxt.run_length   = tok_r.run;
          out_item_nxt.start_column = col_r;
          out_item_nxt.start_row    = row_r;
          out_item_nxt.token_kind   = tok_r.kind;
          last_color_nxt            = color_sel;
          color_nxt                 = color_sel;
          cnt_nxt                   = tok_r.run;
          state_nxt                 = S_WRITE;
        end
      end
      S_WRITE: begin
        // one pixel of the run per cycle, advancing the raster position
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r - RUN_W'(1);
          if (({1'b0, col_r} + WIDTH_W'(1)) == w) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      last_color_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      last_color_r <= last_color_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    step_r     <= step_nxt;
    tok_r      <= tok_nxt;
    color_r    <= color_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

endmodule

// ===== design/prtd_checker.sv =====
// prtd_checker: port-level assertions for pixel_run_token_decoder
// depends on prtd_pkg; bound to the top level at the end of this file
module prtd_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  prtd_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [prtd_pkg::WIDTH_W-1:0] cfg_wdata
);
  import prtd_pkg::*;

  logic [WIDTH_W-1:0] fw_r;
  logic [WIDTH_W-1:0] w;

  // shadow of the width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= RESET_WIDTH;
    end else if (cfg_we) begin
      fw_r <= cfg_wdata;
    end
  end

  assign w = active_width(fw_r);

  // a stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  // runs always start inside the active row width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_item.start_column} < w))
    else $error("start column beyond frame width");

  // copies cover exactly one pixel
  a_copy_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.token_kind == KIND_COPY_TOP ||
                  out_item.token_kind == KIND_COPY_LEFT)
    |-> out_item.run_length == RUN_W'(1))
    else $error("copy token with run other than one");

  // decoded colours sit on the quantisation grid
  a_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.token_kind == KIND_SHORT ||
                  out_item.token_kind == KIND_FULL)
    |-> (out_item.red[3:0] == 4'd0 && out_item.green[2:0] == 3'd0 &&
         out_item.blue[2:0] == 3'd0))
    else $error("colour off quantisation grid");

  // straight out of reset nothing is offered and no byte is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_ready)
    else $error("handshake active straight out of reset");

endmodule

bind pixel_run_token_decoder prtd_checker u_prtd_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for pixel_run_token_decoder, one byte per item
// depends on prtd_pkg and the decoder rtl; predicts every run and checks it in order

module testbench;
  import prtd_pkg::*;

  // longest run plus fold and pipeline, used before width writes and at the end
  localparam int QUIET_CYCLES = 400;
  // cycles with no item moving before the run is declared hung
  localparam int STALL_LIMIT = 20000;

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_THIRD} token_phase_t;

  // predicts decoded runs from stream bytes and checks the result items
  class run_tracker;
    logic [COLOR_W-1:0] line_pixels [MAX_WIDTH];
    logic [WIDTH_W-1:0] width_reg;
    token_phase_t       phase;
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic [COLOR_W-1:0] prev_color;
    int unsigned        col;
    logic [ROW_W-1:0]   row;
    out_item_t          pending_runs[$];
    int                 errors;
    int                 checked;
    int                 kind_count[5];

    function new();
      foreach (line_pixels[i]) line_pixels[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      width_reg   = RESET_WIDTH;
      phase       = PH_FIRST;
      first_byte  = '0;
      second_byte = '0;
      prev_color  = '0;
      col         = 0;
      row         = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_width(logic [WIDTH_W-1:0] w);
      width_reg = w;
    endfunction

    // zero behaves as one, anything past the store size is clamped
    function int unsigned row_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function void emit_run(logic [2:0] kind, logic [COLOR_W-1:0] color, int unsigned run);
      int unsigned w;
      int unsigned idx;
      int unsigned total;
      int unsigned i;
      out_item_t   want;
      w = row_width();
      // column left past the edge by a narrower width: fold it into rows
      if (col >= w) begin
        row = row + ROW_W'(col / w);
        col = col % w;
      end
      if (kind == KIND_COPY_TOP) begin
        color = line_pixels[col];
      end else if (kind == KIND_COPY_LEFT) begin
        color = line_pixels[(col == 0) ? w - 1 : col - 1];
      end
      want.red          = color[23:16];
      want.green        = color[15:8];
      want.blue         = color[7:0];
      want.run_length   = RUN_W'(run);
      want.start_column = COL_W'(col);
      want.start_row    = row;
      want.token_kind   = kind;
      pending_runs.push_back(want);
      // every pixel of the run lands in the line store
      idx = col;
      for (i = 0; i < run; i++) begin
        line_pixels[idx] = color;
        idx++;
        if (idx >= w) idx = 0;
      end
      total      = col + run;
      row        = row + ROW_W'(total / w);
      col        = total % w;
      prev_color = color;
      phase      = PH_FIRST;
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0]  b;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  bl;
      logic [15:0] c;
      b = item.stream_byte;
      if (item.frame_start) begin
        col   = 0;
        row   = '0;
        phase = PH_FIRST;
      end
      case (phase)
        PH_SECOND: begin
          second_byte = b;
          if (b == 8'd0) begin
            emit_run((first_byte == 8'd0) ? KIND_COPY_TOP : KIND_COPY_LEFT, '0, 1);
          end else if (first_byte[6]) begin
            // 2-bit components, black scaling or coarse scaling
            if (b[7]) begin
              r  = {first_byte[5:4], 6'd0};
              g  = {first_byte[3:2], 6'd0};
              bl = {first_byte[1:0], 6'd0};
            end else begin
              r  = {2'd0, first_byte[5:4], 4'd0};
              g  = {3'd0, first_byte[3:2], 3'd0};
              bl = {3'd0, first_byte[1:0], 3'd0};
            end
            emit_run(KIND_SHORT, {r, g, bl}, b[6:0]);
          end else if (first_byte == REPEAT_MARK) begin
            emit_run(KIND_REPEAT, prev_color, b);
          end else begin
            phase = PH_THIRD;
          end
        end
        PH_THIRD: begin
          // 4:5:5 colour from the first and third bytes
          c  = {first_byte, b};
          r  = {c[13:10], 4'd0};
          g  = {c[9:5], 3'd0};
          bl = {c[4:0], 3'd0};
          emit_run(KIND_FULL, {r, g, bl}, second_byte);
        end
        default: begin
          first_byte = b;
          phase      = PH_SECOND;
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_run(out_item_t got);
      out_item_t want;
      bit        ok;
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d column %0d row %0d",
                 $time, got.token_kind, got.start_column, got.start_row);
        errors++;
        return;
      end
      want = pending_runs.pop_front();
      ok = field_ok("red", want.red, got.red);
      ok = field_ok("green", want.green, got.green) && ok;
      ok = field_ok("blue", want.blue, got.blue) && ok;
      ok = field_ok("run_length", want.run_length, got.run_length) && ok;
      ok = field_ok("start_column", want.start_column, got.start_column) && ok;
      ok = field_ok("start_row", want.start_row, got.start_row) && ok;
      ok = field_ok("token_kind", want.token_kind, got.token_kind) && ok;
      if (!ok) errors++;
      checked++;
      kind_count[want.token_kind]++;
    endfunction

    function void report_leftover();
      if (pending_runs.size() != 0) begin
        $display("%0t: %0d runs never arrived, expected kind %0d column %0d row %0d first",
                 $time, pending_runs.size(), pending_runs[0].token_kind,
                 pending_runs[0].start_column, pending_runs[0].start_row);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               cfg_we;
  logic [WIDTH_W-1:0] cfg_wdata;

  run_tracker  sb;
  bit          sender_idles;
  bit          receiver_idles;
  int unsigned bytes_sent;
  int unsigned quiet_count;

  pixel_run_token_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side stalls at random
  always @(negedge clk) begin
    out_ready <= !(receiver_idles && ($urandom_range(0, 99) < 21));
  end

  // item monitor and hang watchdog
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_byte(in_item);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_run(out_item);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while (sender_idles && ($urandom_range(0, 99) < 21)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {b, fs};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_runs.size() != 0) @(negedge clk);
  endtask

  // width only changes once the decoder has gone quiet
  task automatic write_width(input logic [WIDTH_W-1:0] w);
    wait_drained();
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_width(w);
  endtask

  // one well-formed token with random content
  task automatic send_random_token(input bit long_runs);
    int unsigned pick;
    int unsigned run_len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        fs;
    fs = !long_runs && ($urandom_range(0, 99) < 3);
    if (long_runs) begin
      run_len = $urandom_range(192, 255);
      pick    = $urandom_range(30, 99);
    end else begin
      run_len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 15) : $urandom_range(1, 255);
      pick    = $urandom_range(0, 99);
    end
    if (pick < 8) begin
      // copy top
      send_byte(8'h00, fs);
      send_byte(8'h00, 1'b0);
    end else if (pick < 20) begin
      // copy left, any nonzero first byte
      send_byte(8'($urandom_range(1, 255)), fs);
      send_byte(8'h00, 1'b0);
    end else if (pick < 45) begin
      // short colour
      b0 = {1'($urandom_range(0, 1)), 1'b1, 6'($urandom_range(0, 63))};
      b1 = {1'($urandom_range(0, 1)), 7'(run_len)};
      send_byte(b0, fs);
      send_byte(b1, 1'b0);
    end else if (pick < 70) begin
      // repeat previous colour
      send_byte(REPEAT_MARK, fs);
      send_byte(8'(run_len), 1'b0);
    end else begin
      // full colour: bit 6 clear and not the repeat marker
      do begin
        b0    = 8'($urandom_range(0, 255));
        b0[6] = 1'b0;
      end while (b0 == REPEAT_MARK);
      send_byte(b0, fs);
      send_byte(8'(run_len), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // mostly tokens, some stray bytes that break token framing
  task automatic run_phase(input int unsigned n_bytes, input bit long_runs);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if (!long_runs && ($urandom_range(0, 99) < 12)) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 99) < 10));
      end else begin
        send_random_token(long_runs);
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    // bit 8 is frame_start, low byte is the stream byte
    logic [8:0] directed_items[$] = '{
      9'h000, 9'h000,          // copy top at origin, store still clear
      9'h07F, 9'h005,          // short colour, coarse scaling
      9'h07F, 9'h080,          // short colour, black scaling, zero run
      9'h06A, 9'h0FF,          // short colour, longest short run
      9'h080, 9'h0FF,          // repeat previous, longest run
      9'h03F, 9'h0FF, 9'h0FF,  // full colour, every component at maximum
      9'h0BF, 9'h001, 9'h000,  // full colour, top bits of first byte dropped
      9'h000, 9'h003, 9'h0A5,  // full colour with zero first byte
      9'h155, 9'h000,          // frame start then copy left from column 0
      9'h03F, 9'h112, 9'h000   // frame start cutting a token short
    };
    logic [WIDTH_W-1:0] mid_width;

    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    bytes_sent     = 0;
    mid_width      = WIDTH_W'($urandom_range(2, MAX_WIDTH));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed tokens at the reset width
    foreach (directed_items[i]) begin
      send_byte(directed_items[i][7:0], directed_items[i][8]);
    end

    // random tokens across widths, extremes included
    write_width(WIDTH_W'(MAX_WIDTH));
    run_phase(170, 1'b0);
    write_width(13'd17);
    run_phase(170, 1'b0);
    // width zero acts as one: long runs carry the row past its wrap
    write_width(13'd0);
    run_phase(1000, 1'b1);
    write_width(13'd8191);
    run_phase(150, 1'b0);
    write_width(13'd1);
    run_phase(150, 1'b0);
    // stretch with both sides streaming
    write_width(mid_width);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_phase(170, 1'b0);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    write_width(13'd5);
    run_phase(120, 1'b0);

    // drain and let the last run finish in the line store
    wait_drained();
    repeat (QUIET_CYCLES) @(negedge clk);
    sb.report_leftover();

    $display("tb: %0d stream bytes over widths 1920, 4096, 17, 0, 8191, 1, %0d and 5",
             bytes_sent, mid_width);
    $display("tb: %0d runs checked: copy top %0d, copy left %0d, short %0d, repeat %0d, full %0d",
             sb.checked, sb.kind_count[KIND_COPY_TOP], sb.kind_count[KIND_COPY_LEFT],
             sb.kind_count[KIND_SHORT], sb.kind_count[KIND_REPEAT], sb.kind_count[KIND_FULL]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
